FILE: sv/rc4_pkg.sv
package rc4_pkg;

    localparam int BYTE_W        = 8;
    localparam int PERM_DEPTH    = 256;
    localparam int PERM_AW       = $clog2(PERM_DEPTH);
    localparam int MAX_KEY_BYTES = 16;
    localparam int KEY_IDX_W     = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KEY_LEN_W     = 5;
    localparam int KEY_WORD_W    = 64;
    localparam int KEY_W         = 2 * KEY_WORD_W;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd2;

    localparam logic [PERM_AW-1:0] PERM_LAST = PERM_AW'(PERM_DEPTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KS_RD_I,
        ST_KS_RD_J,
        ST_KS_WR_I,
        ST_KS_WR_J,
        ST_PG_RD_A,
        ST_PG_RD_B,
        ST_PG_WR_A,
        ST_PG_WR_B,
        ST_PG_RD_T,
        ST_PG_DONE
    } t_state;

    typedef struct packed {
        logic               we;
        logic [PERM_AW-1:0] waddr;
        logic [BYTE_W-1:0]  wdata;
        logic               re;
        logic [PERM_AW-1:0] raddr;
    } t_ram_req;

endpackage

FILE: sv/rc4_perm_ram.sv
module rc4_perm_ram
    import rc4_pkg::*;
(
    input  logic              i_clk,
    input  t_ram_req          i_req,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [PERM_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/rc4_core.sv
module rc4_core
    import rc4_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_restart,
    input  logic [BYTE_W-1:0]    i_data,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [KEY_LEN_W-1:0] i_key_len,
    input  logic                 i_res_ready,
    output logic                 o_idle,
    output logic                 o_res_valid,
    output logic [BYTE_W-1:0]    o_res_byte
);

    t_state r_state, n_state;

    logic [PERM_AW-1:0]   r_idx, n_idx;     // i during the schedule, a afterwards
    logic [PERM_AW-1:0]   r_j, n_j;         // j during the schedule, b afterwards
    logic [BYTE_W-1:0]    r_si, n_si;
    logic [BYTE_W-1:0]    r_sj, n_sj;
    logic [BYTE_W-1:0]    r_data, n_data;
    logic [KEY_IDX_W-1:0] r_k, n_k;
    logic                 r_keyed, n_keyed;

    t_ram_req          ram_req;
    logic [BYTE_W-1:0] rdata;

    logic [BYTE_W-1:0]    add_a, add_b, add_c, add_sum;
    logic [BYTE_W-1:0]    key_byte;
    logic [KEY_LEN_W-1:0] len_eff;
    logic                 sched_req;

    rc4_perm_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (rdata)
    );

    // shared modulo-256 adder
    assign add_sum = add_a + add_b + add_c;

    always_comb begin
        priority if (i_key_len == '0) begin
            len_eff = KEY_LEN_W'(1);
        end else if (i_key_len > KEY_LEN_W'(MAX_KEY_BYTES)) begin
            len_eff = KEY_LEN_W'(MAX_KEY_BYTES);
        end else begin
            len_eff = i_key_len;
        end
    end

    assign key_byte  = i_key[{r_k, 3'b000} +: BYTE_W];
    assign sched_req = i_restart || !r_keyed;
    assign o_idle    = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = sched_req ? ST_FILL : ST_PG_RD_A;
                end
            end
            ST_FILL: begin
                if (r_idx == PERM_LAST) begin
                    n_state = ST_KS_RD_I;
                end
            end
            ST_KS_RD_I: n_state = ST_KS_RD_J;
            ST_KS_RD_J: n_state = ST_KS_WR_I;
            ST_KS_WR_I: n_state = ST_KS_WR_J;
            ST_KS_WR_J: n_state = (r_idx == PERM_LAST) ? ST_PG_RD_A : ST_KS_RD_I;
            ST_PG_RD_A: n_state = ST_PG_RD_B;
            ST_PG_RD_B: n_state = ST_PG_WR_A;
            ST_PG_WR_A: n_state = ST_PG_WR_B;
            ST_PG_WR_B: n_state = ST_PG_RD_T;
            ST_PG_RD_T: n_state = ST_PG_DONE;
            ST_PG_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_idx       = r_idx;
        n_j         = r_j;
        n_si        = r_si;
        n_sj        = r_sj;
        n_data      = r_data;
        n_k         = r_k;
        n_keyed     = r_keyed;
        add_a       = '0;
        add_b       = '0;
        add_c       = '0;
        ram_req     = '0;
        o_res_valid = 1'b0;
        o_res_byte  = r_data ^ rdata;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_data = i_data;
                    if (sched_req) begin
                        n_idx = '0;
                        n_j   = '0;
                        n_k   = '0;
                    end
                end
            end
            ST_FILL: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_idx;
                ram_req.wdata = BYTE_W'(r_idx);
                n_idx         = r_idx + PERM_AW'(1);
            end
            ST_KS_RD_I: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = r_idx;
            end
            ST_KS_RD_J: begin
                add_a         = BYTE_W'(r_j);
                add_b         = rdata;
                add_c         = key_byte;
                n_j           = PERM_AW'(add_sum);
                n_si          = rdata;
                ram_req.re    = 1'b1;
                ram_req.raddr = PERM_AW'(add_sum);
            end
            ST_KS_WR_I: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_idx;
                ram_req.wdata = rdata;
            end
            ST_KS_WR_J: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_j;
                ram_req.wdata = r_si;
                n_idx         = r_idx + PERM_AW'(1);
                if (r_k == KEY_IDX_W'(len_eff - KEY_LEN_W'(1))) begin
                    n_k = '0;
                end else begin
                    n_k = r_k + KEY_IDX_W'(1);
                end
                // last swap: index a wraps to zero, clear b
                if (r_idx == PERM_LAST) begin
                    n_j     = '0;
                    n_keyed = 1'b1;
                end
            end
            ST_PG_RD_A: begin
                add_a         = BYTE_W'(r_idx);
                add_b         = BYTE_W'(1);
                n_idx         = PERM_AW'(add_sum);
                ram_req.re    = 1'b1;
                ram_req.raddr = PERM_AW'(add_sum);
            end
            ST_PG_RD_B: begin
                add_a         = BYTE_W'(r_j);
                add_b         = rdata;
                n_j           = PERM_AW'(add_sum);
                n_si          = rdata;
                ram_req.re    = 1'b1;
                ram_req.raddr = PERM_AW'(add_sum);
            end
            ST_PG_WR_A: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_idx;
                ram_req.wdata = rdata;
                n_sj          = rdata;
            end
            ST_PG_WR_B: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_j;
                ram_req.wdata = r_si;
            end
            ST_PG_RD_T: begin
                add_a         = r_si;
                add_b         = r_sj;
                ram_req.re    = 1'b1;
                ram_req.raddr = PERM_AW'(add_sum);
            end
            ST_PG_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                n_keyed = r_keyed;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_keyed <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_j     <= n_j;
            r_k     <= n_k;
            r_keyed <= n_keyed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_si   <= n_si;
        r_sj   <= n_sj;
        r_data <= n_data;
    end

endmodule

FILE: sv/rc4_stream_cipher.sv
// RC4 stream cipher, one byte per transaction.
// Input channel (i_in_valid / o_in_ready) carries i_data_byte and i_restart;
// output channel (o_out_valid / i_out_ready) returns o_out_byte, the input
// byte XOR the next keystream byte. Encryption and decryption are identical.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes the
// key: index 0 key bytes 0-7, index 1 key bytes 8-15, index 2 key length
// (0 behaves as 1, above 16 as 16). Other indices are dropped. Write it only
// while the block is idle.
// A plain byte runs one keystream step before o_out_valid: five table
// accesses, one per state, from ST_PG_RD_A to ST_PG_RD_T. With i_restart,
// or on the first byte after reset, the key schedule runs first: a table
// fill of all 256 entries and 256 swaps, each through ST_KS_RD_I, ST_KS_RD_J,
// ST_KS_WR_I and ST_KS_WR_J. The core works on one byte at a time and
// o_in_ready is high only when it is idle; a finished byte may wait in the
// output register meanwhile.
// Reset clears indices, the keyed flag and the output valid; key registers
// return to zero with length 16. If the receiver stalls, the result is held
// in the output register and a finished step waits until the slot frees.
module rc4_stream_cipher
    import rc4_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_restart,
    input  logic [BYTE_W-1:0]     i_data_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [BYTE_W-1:0]     o_out_byte
);

    logic [KEY_WORD_W-1:0] r_key_low, r_key_high;
    logic [KEY_LEN_W-1:0]  r_key_len;
    logic                  r_out_valid;
    logic [BYTE_W-1:0]     r_out_byte;

    logic              core_idle;
    logic              res_valid;
    logic [BYTE_W-1:0] res_byte;
    logic              res_ready;
    logic              in_take;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = core_idle;
    assign in_take     = i_in_valid && core_idle;

    // the output slot is free when empty or being emptied this cycle
    assign res_ready = !r_out_valid || i_out_ready;

    rc4_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_take),
        .i_restart   (i_restart),
        .i_data      (i_data_byte),
        .i_key       ({r_key_high, r_key_low}),
        .i_key_len   (r_key_len),
        .i_res_ready (res_ready),
        .o_idle      (core_idle),
        .o_res_valid (res_valid),
        .o_res_byte  (res_byte)
    );

    // key registers; unknown indices are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_key_len  <= KEY_LEN_W'(MAX_KEY_BYTES);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KEY_LOW:    r_key_low  <= i_cfg_data;
                CFG_KEY_HIGH:   r_key_high <= i_cfg_data;
                CFG_KEY_LENGTH: r_key_len  <= i_cfg_data[KEY_LEN_W-1:0];
                default:        r_key_len  <= r_key_len;
            endcase
        end
    end

    // output register: load a finished result, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_byte <= res_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;

endmodule
